>>> rtl/hsv_pkg.sv
package hsv_pkg;

    // 254 is full scale on hue, saturation and level
    localparam logic [7:0]  C_FULL  = 8'd254;
    // 254^2, the numerator of a full component
    localparam logic [15:0] C_SQ    = 16'd64516;
    // 254^3, the common denominator
    localparam logic [23:0] C_DEN   = 24'd16387064;
    // 255 * floor(2^32 / 254^3), scaled reciprocal for the quotient estimate
    localparam logic [16:0] C_RECIP = 17'd66810;

    // hue*6 sector boundaries
    localparam logic [10:0] C_H6_1 = 11'd254;
    localparam logic [10:0] C_H6_2 = 11'd508;
    localparam logic [10:0] C_H6_3 = 11'd762;
    localparam logic [10:0] C_H6_4 = 11'd1016;
    localparam logic [10:0] C_H6_5 = 11'd1270;

    typedef enum logic [2:0] {
        SEC_0,
        SEC_1,
        SEC_2,
        SEC_3,
        SEC_4,
        SEC_5
    } t_sector;

    typedef struct packed {
        t_sector     sector;
        logic [7:0]  lvl;
        logic [15:0] num_p;
        logic [15:0] num_q;
        logic [15:0] num_t;
    } t_nums;

endpackage

>>> rtl/hsv_front.sv
module hsv_front
    import hsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_level,
    output logic       o_valid,
    output t_nums      o_nums
);

    logic [10:0] h6;
    t_sector     n_sector;
    logic [7:0]  n_frac;
    logic [7:0]  n_sat;
    logic [7:0]  n_lvl;

    logic        r1_vld;
    t_sector     r1_sector;
    logic [7:0]  r1_frac;
    logic [7:0]  r1_sat;
    logic [7:0]  r1_lvl;

    t_nums       n_nums;
    logic        r2_vld;
    t_nums       r2_nums;

    // stage 1: clamp, sector and fraction
    always_comb begin
        n_sat = (i_saturation > C_FULL) ? C_FULL : i_saturation;
        n_lvl = (i_level > C_FULL) ? C_FULL : i_level;
        h6    = 11'({3'b000, i_hue} << 2) + 11'({3'b000, i_hue} << 1);
        if (i_hue >= C_FULL) begin
            n_sector = SEC_0;
            n_frac   = 8'd0;
        end else if (h6 < C_H6_1) begin
            n_sector = SEC_0;
            n_frac   = h6[7:0];
        end else if (h6 < C_H6_2) begin
            n_sector = SEC_1;
            n_frac   = 8'(h6 - C_H6_1);
        end else if (h6 < C_H6_3) begin
            n_sector = SEC_2;
            n_frac   = 8'(h6 - C_H6_2);
        end else if (h6 < C_H6_4) begin
            n_sector = SEC_3;
            n_frac   = 8'(h6 - C_H6_3);
        end else if (h6 < C_H6_5) begin
            n_sector = SEC_4;
            n_frac   = 8'(h6 - C_H6_4);
        end else begin
            n_sector = SEC_5;
            n_frac   = 8'(h6 - C_H6_5);
        end
    end

    // stage 2: numerators over 254^2
    always_comb begin
        n_nums.sector = r1_sector;
        n_nums.lvl    = r1_lvl;
        n_nums.num_p  = 16'(8'(C_FULL - r1_sat)) * 16'(C_FULL);
        n_nums.num_q  = C_SQ - 16'(r1_sat) * 16'(r1_frac);
        n_nums.num_t  = C_SQ - 16'(r1_sat) * 16'(8'(C_FULL - r1_frac));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sector <= n_sector;
        r1_frac   <= n_frac;
        r1_sat    <= n_sat;
        r1_lvl    <= n_lvl;
        r2_nums   <= n_nums;
    end

    assign o_valid = r2_vld;
    assign o_nums  = r2_nums;

endmodule

>>> rtl/hsv_scale.sv
module hsv_scale
    import hsv_pkg::*;
(
    input  logic        i_clk,
    input  logic [7:0]  i_lvl,
    input  logic [15:0] i_num,
    output logic [7:0]  o_q
);

    // floor(lvl * num * 255 / 254^3) over three stages
    logic [23:0] n_x;
    logic [23:0] r_x;
    logic [31:0] n_y;
    logic [40:0] n_prod;
    logic [31:0] r_y;
    logic [7:0]  r_q0;
    logic [31:0] n_rem;
    logic [7:0]  n_q;
    logic [7:0]  r_q;

    always_comb begin
        n_x    = 24'(i_lvl) * 24'(i_num);
        n_y    = {r_x, 8'h00} - 32'(r_x);
        // estimate is low by at most one
        n_prod = 41'(r_x) * 41'(C_RECIP);
        n_rem  = r_y - 32'(r_q0) * 32'(C_DEN);
        n_q    = r_q0 + ((n_rem >= 32'(C_DEN)) ? 8'd1 : 8'd0);
    end

    always_ff @(posedge i_clk) begin
        r_x  <= n_x;
        r_y  <= n_y;
        r_q0 <= n_prod[39:32];
        r_q  <= n_q;
    end

    assign o_q = r_q;

endmodule

>>> rtl/hsv_to_rgb_8bit_top.sv
// HSV to RGB conversion, 8-bit hue/saturation/level in, 8-bit red/green/blue out.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Depth: front end, scale unit (product, reciprocal estimate, correction), output register.
// Reset (synchronous, active low) clears the valid bits only; no item is in flight after it.
module hsv_to_rgb_8bit_top
    import hsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_hue,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_level,
    output logic       o_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic       front_vld;
    t_nums      front_nums;
    logic [7:0] cv;
    logic [7:0] cp;
    logic [7:0] cq;
    logic [7:0] ct;

    logic       r_vld_d [3];
    t_sector    r_sec_d [3];

    logic [7:0] n_red;
    logic [7:0] n_green;
    logic [7:0] n_blue;
    logic       r_out_vld;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;

    assign busy = 1'b0;

    hsv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_level      (i_level),
        .o_valid      (front_vld),
        .o_nums       (front_nums)
    );

    hsv_scale u_scale_v (
        .i_clk (i_clk),
        .i_lvl (front_nums.lvl),
        .i_num (C_SQ),
        .o_q   (cv)
    );

    hsv_scale u_scale_p (
        .i_clk (i_clk),
        .i_lvl (front_nums.lvl),
        .i_num (front_nums.num_p),
        .o_q   (cp)
    );

    hsv_scale u_scale_q (
        .i_clk (i_clk),
        .i_lvl (front_nums.lvl),
        .i_num (front_nums.num_q),
        .o_q   (cq)
    );

    hsv_scale u_scale_t (
        .i_clk (i_clk),
        .i_lvl (front_nums.lvl),
        .i_num (front_nums.num_t),
        .o_q   (ct)
    );

    always_comb begin
        case (r_sec_d[2])
            SEC_0: begin
                n_red = cv; n_green = ct; n_blue = cp;
            end
            SEC_1: begin
                n_red = cq; n_green = cv; n_blue = cp;
            end
            SEC_2: begin
                n_red = cp; n_green = cv; n_blue = ct;
            end
            SEC_3: begin
                n_red = cp; n_green = cq; n_blue = cv;
            end
            SEC_4: begin
                n_red = ct; n_green = cp; n_blue = cv;
            end
            default: begin
                n_red = cv; n_green = cp; n_blue = cq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d[0] <= 1'b0;
            r_vld_d[1] <= 1'b0;
            r_vld_d[2] <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_vld_d[0] <= front_vld;
            r_vld_d[1] <= r_vld_d[0];
            r_vld_d[2] <= r_vld_d[1];
            r_out_vld  <= r_vld_d[2];
        end
    end

    // sector rides alongside the scale units
    always_ff @(posedge i_clk) begin
        r_sec_d[0] <= front_nums.sector;
        r_sec_d[1] <= r_sec_d[0];
        r_sec_d[2] <= r_sec_d[1];
        r_red      <= n_red;
        r_green    <= n_green;
        r_blue     <= n_blue;
    end

    assign o_valid = r_out_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##6 o_valid)
        else $error("accepted item did not come out after 6 cycles");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_saturation == 8'd0) |-> ##6 (o_red == o_green && o_green == o_blue))
        else $error("zero saturation did not give grey");

    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_level == 8'd0) |->
            ##6 (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("zero level did not give black");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output strobe after reset");

endmodule
